// ===== src/mau_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Holds the command codes and the packed item types for the input and result
// channels.
// ----------------------------------------------------------------------------
package mau_pkg;

  // Command codes carried in the input item.
  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_SUB    = 3'd1;
  localparam logic [2:0] CMD_MUL    = 3'd2;
  localparam logic [2:0] CMD_DIV    = 3'd3;
  localparam logic [2:0] CMD_NEG    = 3'd4;
  localparam logic [2:0] CMD_INV    = 3'd5;
  localparam logic [2:0] CMD_REDUCE = 3'd6;
  // Unassigned code; the block answers it with a zero result.
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  // One input item.
  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [63:0] result_value;
    logic        not_invertible;
  } out_item_t;

endpackage

// ===== src/modular_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Add, subtract, multiply, divide, negate, invert and reduce modulo a
// configurable modulus, with an extended Euclid inverse.
// ----------------------------------------------------------------------------
// The block takes one item at a time and holds in_stall high until the result
// item has been taken. Both operands are first reduced by restoring division,
// one bit per cycle. Add, subtract, negate and reduce then finish in S_EXEC.
// Multiply runs a shift-add loop through the single modular adder, a doubling
// step and an add step for each multiplier bit. Invert runs the extended
// Euclid algorithm: each round divides bit-serially while it accumulates the
// quotient times the coefficient modulo the modulus, and the number of rounds
// grows with the operand size (about 1.44*WIDTH at worst). Divide is an invert
// followed by a multiply. The modulus register is written over its own
// valid/ready port while the block is idle; only its low WIDTH bits are used,
// and a zero modulus or an unused command returns zero.
module modular_arithmetic_unit #(
  parameter int WIDTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mau_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mau_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [63:0]         cfg_data
);

  localparam int CW = $clog2(WIDTH);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RED  = 10'b0000000010,
    S_EXEC = 10'b0000000100,
    S_MDBL = 10'b0000001000,
    S_MADD = 10'b0000010000,
    S_ECHK = 10'b0000100000,
    S_EDIV = 10'b0001000000,
    S_EADD = 10'b0010000000,
    S_EUPD = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t           state;
  logic [WIDTH-1:0] modulus;
  logic [2:0]       cmd;
  logic [WIDTH-1:0] a_sh, b_sh;
  logic [WIDTH-1:0] ra, rb;
  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] acc, mx, my;
  logic [WIDTH-1:0] r0, r1, t0, t1;
  logic [WIDTH-1:0] d_sh, drem;
  logic             qbit;
  logic [WIDTH-1:0] res;
  logic             flag;

  // Reduction steps for both operands.
  logic [WIDTH:0] ra_ext, rb_ext, ra_sub, rb_sub;
  always_comb begin
    ra_ext = {ra, a_sh[WIDTH-1]};
    rb_ext = {rb, b_sh[WIDTH-1]};
    ra_sub = ra_ext - {1'b0, modulus};
    rb_sub = rb_ext - {1'b0, modulus};
  end

  // Shared modular adder.
  logic [WIDTH-1:0] am_x, am_y, am_out;
  logic [WIDTH:0]   am_sum;
  always_comb begin
    case (state)
      S_EXEC:  begin am_x = ra;  am_y = rb;  end
      S_MADD:  begin am_x = acc; am_y = mx;  end
      S_EADD:  begin am_x = acc; am_y = t1;  end
      default: begin am_x = acc; am_y = acc; end
    endcase
    am_sum = {1'b0, am_x} + {1'b0, am_y};
    if (am_sum >= {1'b0, modulus}) begin
      am_sum = am_sum - {1'b0, modulus};
    end
    am_out = am_sum[WIDTH-1:0];
  end

  // Modular subtractor.
  logic [WIDTH-1:0] sm_x, sm_y, sm_out;
  always_comb begin
    if (state == S_EUPD) begin
      sm_x = t0;
      sm_y = acc;
    end else if (cmd == mau_pkg::CMD_NEG) begin
      sm_x = '0;
      sm_y = ra;
    end else begin
      sm_x = ra;
      sm_y = rb;
    end
    sm_out = (sm_x >= sm_y) ? (sm_x - sm_y) : (sm_x - sm_y + modulus);
  end

  // Euclid division step.
  logic [WIDTH:0] d_ext;
  logic           d_ge;
  always_comb begin
    d_ext = {drem, d_sh[WIDTH-1]};
    d_ge  = d_ext >= {1'b0, r1};
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);
  assign cfg_ready = (state == S_IDLE);
  assign out_item.result_value   = 64'(res);
  assign out_item.not_invertible = flag;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      modulus <= WIDTH'(1);
    end else begin
      if (cfg_valid && cfg_ready) begin
        modulus <= cfg_data[WIDTH-1:0];
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd  <= in_item.command;
            a_sh <= in_item.operand_a[WIDTH-1:0];
            b_sh <= in_item.operand_b[WIDTH-1:0];
            ra   <= '0;
            rb   <= '0;
            cnt  <= CW'(WIDTH - 1);
            if (modulus == '0) begin
              res   <= '0;
              flag  <= 1'b0;
              state <= S_DONE;
            end else begin
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          ra   <= ra_sub[WIDTH] ? ra_ext[WIDTH-1:0] : ra_sub[WIDTH-1:0];
          rb   <= rb_sub[WIDTH] ? rb_ext[WIDTH-1:0] : rb_sub[WIDTH-1:0];
          a_sh <= a_sh << 1;
          b_sh <= b_sh << 1;
          if (cnt == '0) begin
            state <= S_EXEC;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_EXEC: begin
          flag <= 1'b0;
          acc  <= '0;
          cnt  <= CW'(WIDTH - 1);
          r0   <= modulus;
          t0   <= '0;
          t1   <= (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
          case (cmd)
            mau_pkg::CMD_ADD: begin
              res   <= am_out;
              state <= S_DONE;
            end
            mau_pkg::CMD_SUB, mau_pkg::CMD_NEG: begin
              res   <= sm_out;
              state <= S_DONE;
            end
            mau_pkg::CMD_REDUCE: begin
              res   <= ra;
              state <= S_DONE;
            end
            mau_pkg::CMD_MUL: begin
              mx    <= ra;
              my    <= rb;
              state <= S_MDBL;
            end
            mau_pkg::CMD_DIV: begin
              r1    <= rb;
              state <= S_ECHK;
            end
            mau_pkg::CMD_INV: begin
              r1    <= ra;
              state <= S_ECHK;
            end
            default: begin
              res   <= '0;
              state <= S_DONE;
            end
          endcase
        end
        S_MDBL: begin
          acc   <= am_out;
          state <= S_MADD;
        end
        S_MADD: begin
          if (my[cnt]) begin
            acc <= am_out;
          end
          if (cnt == '0) begin
            res   <= my[cnt] ? am_out : acc;
            state <= S_DONE;
          end else begin
            cnt   <= cnt - 1'b1;
            state <= S_MDBL;
          end
        end
        S_ECHK: begin
          acc  <= '0;
          drem <= '0;
          d_sh <= r0;
          cnt  <= CW'(WIDTH - 1);
          if (r1 == '0) begin
            if (r0 != WIDTH'(1)) begin
              res   <= '0;
              flag  <= 1'b1;
              state <= S_DONE;
            end else if (cmd == mau_pkg::CMD_INV) begin
              res   <= t0;
              state <= S_DONE;
            end else begin
              // Division: multiply a by the inverse just found.
              mx    <= ra;
              my    <= t0;
              state <= S_MDBL;
            end
          end else begin
            state <= S_EDIV;
          end
        end
        S_EDIV: begin
          qbit  <= d_ge;
          drem  <= d_ge ?
                   WIDTH'(d_ext - {1'b0, r1}) : d_ext[WIDTH-1:0];
          d_sh  <= d_sh << 1;
          acc   <= am_out;
          state <= S_EADD;
        end
        S_EADD: begin
          if (qbit) begin
            acc <= am_out;
          end
          if (cnt == '0) begin
            state <= S_EUPD;
          end else begin
            cnt   <= cnt - 1'b1;
            state <= S_EDIV;
          end
        end
        S_EUPD: begin
          // New remainder and coefficient; shift the pair down.
          t1    <= sm_out;
          t0    <= t1;
          r0    <= r1;
          r1    <= drem;
          state <= S_ECHK;
        end
        S_DONE: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Modular arithmetic unit testbench
// Drives commands with random operands through several moduli and checks
// every result item against a predictor kept inside a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDTH = 64;
  localparam int CYCLE_LIMIT = 60000000;

  // Predicts modular results and holds those still owed by the block.
  class mod_result_board;
    logic [63:0] ring_mod;
    mau_pkg::out_item_t owed_results[$];
    int unsigned mismatches;

    function new();
      ring_mod = 64'd1;
      mismatches = 0;
    endfunction

    function logic [63:0] add_m(logic [63:0] x, logic [63:0] y, logic [63:0] m);
      logic [64:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[63:0];
    endfunction

    function logic [63:0] sub_m(logic [63:0] x, logic [63:0] y, logic [63:0] m);
      return (x >= y) ? x - y : x - y + m;
    endfunction

    function logic [63:0] mul_m(logic [63:0] x, logic [63:0] y, logic [63:0] m);
      logic [127:0] p;
      p = {64'd0, x} * {64'd0, y};
      return 64'(p % {64'd0, m});
    endfunction

    // Extended Euclid; returns 1 when the gcd is one.
    function bit inv_m(logic [63:0] x, logic [63:0] m, output logic [63:0] inv);
      logic [63:0] r0, r1, t0, t1, q, nr, nt;
      r0 = m; r1 = x; t0 = 0; t1 = 64'd1 % m;
      while (r1 != 0) begin
        q = r0 / r1;
        nr = r0 - q * r1;
        nt = sub_m(t0, mul_m(q % m, t1, m), m);
        r0 = r1; r1 = nr; t0 = t1; t1 = nt;
      end
      inv = t0;
      return r0 == 64'd1;
    endfunction

    function void note_input(mau_pkg::in_item_t it);
      mau_pkg::out_item_t e;
      logic [63:0] m, a, b, inv;
      e = '0;
      m = ring_mod;
      if (m != 0) begin
        a = it.operand_a % m;
        b = it.operand_b % m;
        case (it.command)
          mau_pkg::CMD_ADD: e.result_value = add_m(a, b, m);
          mau_pkg::CMD_SUB: e.result_value = sub_m(a, b, m);
          mau_pkg::CMD_MUL: e.result_value = mul_m(a, b, m);
          mau_pkg::CMD_DIV: begin
            if (inv_m(b, m, inv)) e.result_value = mul_m(a, inv, m);
            else e.not_invertible = 1'b1;
          end
          mau_pkg::CMD_NEG: e.result_value = sub_m(64'd0, a, m);
          mau_pkg::CMD_INV: begin
            if (inv_m(a, m, inv)) e.result_value = inv;
            else e.not_invertible = 1'b1;
          end
          mau_pkg::CMD_REDUCE: e.result_value = a;
          default: e.result_value = 64'd0;
        endcase
      end
      owed_results.push_back(e);
    endfunction

    function void check_result(mau_pkg::out_item_t got);
      mau_pkg::out_item_t e;
      if (owed_results.size() == 0) begin
        report_bad($sformatf("unexpected result %h", got));
        return;
      end
      e = owed_results.pop_front();
      if (got.result_value !== e.result_value)
        report_bad($sformatf("result_value %h, expected %h", got.result_value,
                             e.result_value));
      if (got.not_invertible !== e.not_invertible)
        report_bad($sformatf("not_invertible %b, expected %b", got.not_invertible,
                             e.not_invertible));
    endfunction

    function void report_bad(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  mau_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mau_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [63:0] cfg_data = '0;

  mod_result_board board = new();
  int unsigned cycle_count = 0;
  bit calm = 1'b0;       // no idling on either side
  int hold_cycles = 0;   // receiver hold-off requested

  modular_arithmetic_unit #(.WIDTH(WIDTH)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Cycle counter with a timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result sampling.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_item);
  end

  // Receiver stall, with an optional long hold-off.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 26);
    end
  end

  // Offers one item at a falling edge and waits until it is accepted.
  task automatic send_item(input logic [2:0] cmd, input logic [63:0] a,
                           input logic [63:0] b);
    mau_pkg::in_item_t it;
    it.command = cmd;
    it.operand_a = a;
    it.operand_b = b;
    do @(negedge clk); while (!calm && $urandom_range(99) < 26);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(it);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_modulus(input logic [63:0] m);
    while (board.owed_results.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.ring_mod = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand_wide();
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(20));
      2: return ~64'($urandom_range(20));
      default: return {$urandom, $urandom} >> $urandom_range(63);
    endcase
  endfunction

  task automatic random_phase(input int n);
    logic [2:0] cmd;
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(49) == 0) ? mau_pkg::CMD_UNUSED : 3'($urandom_range(6));
      send_item(cmd, rand_wide(), rand_wide());
    end
  endtask

  logic [63:0] moduli [8];

  initial begin
    moduli[0] = 64'd1;
    moduli[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    moduli[2] = 64'hFFFF_FFFF_FFFF_FFC5;   // large prime
    moduli[3] = 64'd97;
    moduli[4] = 64'd360;
    moduli[5] = 64'd0;
    moduli[6] = 64'h8000_0000_0000_0000;
    moduli[7] = 64'd2;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed items at the reset modulus of one, then at a composite, at zero and at all ones.
    send_item(mau_pkg::CMD_INV, 64'd5, 64'd0);
    send_item(mau_pkg::CMD_DIV, 64'd5, 64'd3);
    write_modulus(64'd360);
    send_item(mau_pkg::CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(mau_pkg::CMD_SUB, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(mau_pkg::CMD_MUL, 64'hFFFF_FFFF_FFFF_FFFF, 64'd359);
    send_item(mau_pkg::CMD_DIV, 64'd7, 64'd11);
    send_item(mau_pkg::CMD_DIV, 64'd7, 64'd12);    // not invertible
    send_item(mau_pkg::CMD_NEG, 64'd0, 64'd0);
    send_item(mau_pkg::CMD_NEG, 64'd1, 64'd0);
    send_item(mau_pkg::CMD_INV, 64'd7, 64'd0);
    send_item(mau_pkg::CMD_INV, 64'd6, 64'd0);     // not invertible
    send_item(mau_pkg::CMD_INV, 64'd0, 64'd0);     // zero operand
    send_item(mau_pkg::CMD_REDUCE, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    send_item(mau_pkg::CMD_UNUSED, 64'd5, 64'd5);
    write_modulus(64'd0);
    send_item(mau_pkg::CMD_ADD, 64'd3, 64'd4);
    send_item(mau_pkg::CMD_INV, 64'd3, 64'd0);
    write_modulus(64'hFFFF_FFFF_FFFF_FFFF);
    send_item(mau_pkg::CMD_MUL, 64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFE);
    send_item(mau_pkg::CMD_INV, 64'hFFFF_FFFF_FFFF_FFFE, 64'd0);
    send_item(mau_pkg::CMD_DIV, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);

    // Random phases over several moduli, with a calm stretch and a hold-off.
    for (int p = 0; p < 10; p++) begin
      if (p < 8) write_modulus(moduli[p]);
      else write_modulus(p == 8 ? 64'd1000003 : {$urandom, $urandom} | 64'd1);
      calm = (p == 3);
      if (p == 5) hold_cycles = 2000;
      random_phase(145);
    end
    calm = 1'b0;

    while (board.owed_results.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/mau_pkg.sv
src/modular_arithmetic_unit.sv
bench/tb_top.sv
